// File: sv/pphc_pkg.sv
// Package for the position-hold controller: constants, state type and arithmetic helpers.
`timescale 1ns / 1ps
`default_nettype none
package pphc_pkg;

   localparam int FILTER_TAU   = 1966;
   localparam int CORDIC_STEPS = 16;
   localparam int GRAVITY_Q16  = 642690;
   localparam int DT_MAX       = 3276;

   localparam int REQ_W       = 280;
   localparam int RSP_W       = 200;
   localparam int CFG_W       = 24;
   localparam int REG_COUNT   = 8;
   localparam int CSR_INDEX_W = 4;
   localparam int DIV_W       = 48;
   localparam int DIVISOR_W   = 17;

   localparam logic [2:0] REG_GAIN_P     = 3'd0;
   localparam logic [2:0] REG_GAIN_I     = 3'd1;
   localparam logic [2:0] REG_GAIN_D     = 3'd2;
   localparam logic [2:0] REG_INT_CLAMP  = 3'd3;
   localparam logic [2:0] REG_ACCEL_FF   = 3'd4;
   localparam logic [2:0] REG_PITCH_FF   = 3'd5;
   localparam logic [2:0] REG_ANGLE_CLMP = 3'd6;
   localparam logic [2:0] REG_SLEW       = 3'd7;

   localparam logic [CFG_W-1:0] CFG_RESET [REG_COUNT] = '{
      24'd45875, 24'd9830, 24'd22938, 24'd3277, 24'd0, 24'd65536, 24'd3431, 24'd22938
   };

   typedef enum logic [4:0] {
      ST_IDLE, ST_PREP, ST_FMUL, ST_FLOAD, ST_FDIV, ST_FUPD, ST_CORD,
      ST_FFA, ST_FFB, ST_FFC, ST_IMUL, ST_IADD, ST_FB0, ST_FB1, ST_FB2, ST_FB3,
      ST_REQ, ST_SLEW, ST_OUT
   } state_type;

   function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
      if (v > 48'sd2147483647) begin
         return 32'sh7fffffff;
      end else if (v < -48'sd2147483648) begin
         return 32'sh80000000;
      end
      return v[31:0];
   endfunction

   function automatic logic signed [31:0] round_q16(input logic signed [58:0] p);
      logic [58:0]        mag;
      logic [42:0]        q;
      logic signed [47:0] r;
      mag = p[58] ? $unsigned(-p) : $unsigned(p);
      q   = 43'((mag + 59'd32768) >> 16);
      r   = p[58] ? -$signed({5'b0, q}) : $signed({5'b0, q});
      return sat32(r);
   endfunction

   function automatic logic signed [47:0] clamp(input logic signed [47:0] v,
                                                input logic [CFG_W-1:0] lim);
      logic signed [47:0] l;
      l = $signed({24'b0, lim});
      if (v > l) begin
         return l;
      end else if (v < -l) begin
         return -l;
      end
      return v;
   endfunction

   function automatic logic [15:0] atan_entry(input logic [4:0] i);
      case (i)
         5'd0:    return 16'd51472;
         5'd1:    return 16'd30385;
         5'd2:    return 16'd16055;
         5'd3:    return 16'd8150;
         5'd4:    return 16'd4091;
         5'd5:    return 16'd2047;
         5'd6:    return 16'd1024;
         5'd7:    return 16'd512;
         5'd8:    return 16'd256;
         5'd9:    return 16'd128;
         5'd10:   return 16'd64;
         5'd11:   return 16'd32;
         5'd12:   return 16'd16;
         5'd13:   return 16'd8;
         5'd14:   return 16'd4;
         5'd15:   return 16'd2;
         5'd16:   return 16'd1;
         default: return 16'd0;
      endcase
   endfunction

endpackage
`default_nettype wire

// File: sv/pid_position_hold_controller_unit.sv
// Top level of the position-hold angle controller: sequencer over one shared multiplier.
`timescale 1ns / 1ps
`default_nettype none
// One item at a time. A reset item or a rejected step goes from idle straight to the output
// state. A step with feedforward is dominated by a 48-bit restoring divider for the filter
// gain and 16 CORDIC iterations, and takes longer when the integral is held and the feedback
// rerun. A step without feedforward is paced by the shared 24x34 multiplier, used once per
// gain product. The result then waits in the output register until taken. Register writes
// are taken only while no item is in flight.
module pid_position_hold_controller_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // target_position, measured_position, measured_velocity, longitudinal_accel, body_pitch,
   // time_step, feedforward_on, feedback_on, accel_bias, pitch_bias, initial_angle
   input  logic [pphc_pkg::REQ_W-1:0]           req_tdata,
   // command
   input  logic [0:0]                           req_tuser,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // accepted, command_angle, position_error, filtered_accel, feedback_term,
   // feedforward_term, requested_angle, feedforward_active, angle_limited, rate_limited
   output logic [pphc_pkg::RSP_W-1:0]           rsp_tdata,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [pphc_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [pphc_pkg::CFG_W-1:0]           csr_data
);

   pphc_pkg::state_type state_ff, state_in;

   logic [pphc_pkg::CFG_W-1:0] cfg_ff [pphc_pkg::REG_COUNT];

   logic signed [31:0] integ_ff, filt_ff, last_ff, aoff_ff, poff_ff;
   logic               ready_ff;

   logic signed [31:0] tp_ff, mp_ff, vel_ff, accel_ff, pitch_ff;
   logic [15:0]        dt_ff;
   logic               ffon_ff, fbon_ff;
   logic signed [31:0] err_ff, u_ff, pu_ff;

   logic signed [58:0] prod_ff;
   logic [pphc_pkg::CFG_W-1:0] mul_g;
   logic signed [33:0] mul_v;
   logic signed [31:0] rs;

   logic [pphc_pkg::DIV_W-1:0] num_ff;
   logic [pphc_pkg::DIVISOR_W:0] rem_ff;
   logic               neg_ff;
   logic [5:0]         cnt_ff;

   logic signed [35:0] x_ff, y_ff;
   logic signed [31:0] z_ff;

   logic signed [31:0] t1_ff, ffterm_ff, fb_ff, cand_ff, req_ff, lim_ff;
   logic signed [33:0] acc_ff;
   logic               retry_ff, alim_ff;

   logic               o_acc_ff, o_ffa_ff, o_alim_ff, o_rlim_ff;
   logic signed [31:0] o_cmd_ff, o_err_ff, o_filt_ff, o_fb_ff, o_ff_ff, o_req_ff;

   logic               in_fire, step_ok, retry_go;
   logic [pphc_pkg::DIVISOR_W-1:0] divisor;
   logic [pphc_pkg::DIVISOR_W:0]   trial;
   logic signed [31:0] req_c, lim_c, filt_c;
   logic signed [47:0] fsum;
   logic [58:0]        pmag;

   assign in_fire   = req_tvalid && req_tready;
   assign csr_ready = (state_ff == pphc_pkg::ST_IDLE);
   assign rs        = pphc_pkg::round_q16(prod_ff);
   assign divisor   = pphc_pkg::DIVISOR_W'(pphc_pkg::FILTER_TAU) + {1'b0, dt_ff};
   assign trial     = {rem_ff[pphc_pkg::DIVISOR_W-1:0], num_ff[pphc_pkg::DIV_W-1]};
   assign pmag      = prod_ff[58] ? $unsigned(-prod_ff) : $unsigned(prod_ff);
   assign fsum      = {{16{filt_ff[31]}}, filt_ff}
                    + (neg_ff ? -$signed(num_ff) : $signed(num_ff));
   assign filt_c    = pphc_pkg::sat32(fsum);

   assign step_ok = ready_ff && (req_tdata[175:160] != 16'd0)
                 && (req_tdata[175:160] <= 16'(pphc_pkg::DT_MAX))
                 && (cfg_ff[pphc_pkg::REG_ANGLE_CLMP] != '0)
                 && (cfg_ff[pphc_pkg::REG_SLEW] != '0);

   assign req_c = pphc_pkg::sat32(48'(fb_ff) + 48'(ffterm_ff));
   assign lim_c = 32'(pphc_pkg::clamp(48'(req_c), cfg_ff[pphc_pkg::REG_ANGLE_CLMP]));
   assign retry_go = (lim_c != req_c) && fbon_ff && !retry_ff
                  && ((req_c > 0 && err_ff > 0) || (req_c < 0 && err_ff < 0));

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         pphc_pkg::ST_IDLE: begin
            if (in_fire) begin
               state_in = (req_tuser[0] || !step_ok) ? pphc_pkg::ST_OUT : pphc_pkg::ST_PREP;
            end
         end
         pphc_pkg::ST_PREP: begin
            if (ffon_ff) begin
               state_in = pphc_pkg::ST_FMUL;
            end else if (fbon_ff) begin
               state_in = pphc_pkg::ST_IMUL;
            end else begin
               state_in = pphc_pkg::ST_REQ;
            end
         end
         pphc_pkg::ST_FMUL:  state_in = pphc_pkg::ST_FLOAD;
         pphc_pkg::ST_FLOAD: state_in = pphc_pkg::ST_FDIV;
         pphc_pkg::ST_FDIV: begin
            if (cnt_ff == 6'(pphc_pkg::DIV_W - 1)) begin
               state_in = pphc_pkg::ST_FUPD;
            end
         end
         pphc_pkg::ST_FUPD:  state_in = pphc_pkg::ST_CORD;
         pphc_pkg::ST_CORD: begin
            if (cnt_ff == 6'(pphc_pkg::CORDIC_STEPS - 1)) begin
               state_in = pphc_pkg::ST_FFA;
            end
         end
         pphc_pkg::ST_FFA:   state_in = pphc_pkg::ST_FFB;
         pphc_pkg::ST_FFB:   state_in = pphc_pkg::ST_FFC;
         pphc_pkg::ST_FFC:   state_in = fbon_ff ? pphc_pkg::ST_IMUL : pphc_pkg::ST_REQ;
         pphc_pkg::ST_IMUL:  state_in = pphc_pkg::ST_IADD;
         pphc_pkg::ST_IADD:  state_in = pphc_pkg::ST_FB0;
         pphc_pkg::ST_FB0:   state_in = pphc_pkg::ST_FB1;
         pphc_pkg::ST_FB1:   state_in = pphc_pkg::ST_FB2;
         pphc_pkg::ST_FB2:   state_in = pphc_pkg::ST_FB3;
         pphc_pkg::ST_FB3:   state_in = pphc_pkg::ST_REQ;
         pphc_pkg::ST_REQ:   state_in = retry_go ? pphc_pkg::ST_FB0 : pphc_pkg::ST_SLEW;
         pphc_pkg::ST_SLEW:  state_in = pphc_pkg::ST_OUT;
         pphc_pkg::ST_OUT: begin
            if (rsp_tready) begin
               state_in = pphc_pkg::ST_IDLE;
            end
         end
         default: state_in = pphc_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_tready = (state_ff == pphc_pkg::ST_IDLE);
      rsp_tvalid = (state_ff == pphc_pkg::ST_OUT);
      mul_g      = '0;
      mul_v      = '0;
      unique case (state_ff)
         pphc_pkg::ST_FMUL: begin
            mul_g = {8'b0, dt_ff};
            mul_v = 34'(u_ff) - 34'(filt_ff);
         end
         pphc_pkg::ST_FFA: begin
            mul_g = cfg_ff[pphc_pkg::REG_ACCEL_FF];
            mul_v = 34'(z_ff);
         end
         pphc_pkg::ST_FFB: begin
            mul_g = cfg_ff[pphc_pkg::REG_PITCH_FF];
            mul_v = 34'(pu_ff);
         end
         pphc_pkg::ST_IMUL: begin
            mul_g = {8'b0, dt_ff};
            mul_v = 34'(err_ff);
         end
         pphc_pkg::ST_FB0: begin
            mul_g = cfg_ff[pphc_pkg::REG_GAIN_P];
            mul_v = 34'(err_ff);
         end
         pphc_pkg::ST_FB1: begin
            mul_g = cfg_ff[pphc_pkg::REG_GAIN_I];
            mul_v = 34'(cand_ff);
         end
         pphc_pkg::ST_FB2: begin
            mul_g = cfg_ff[pphc_pkg::REG_GAIN_D];
            mul_v = 34'(vel_ff);
         end
         pphc_pkg::ST_REQ: begin
            mul_g = cfg_ff[pphc_pkg::REG_SLEW];
            mul_v = $signed({18'b0, dt_ff});
         end
         default: begin
            mul_g = '0;
            mul_v = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pphc_pkg::ST_IDLE;
         for (int i = 0; i < pphc_pkg::REG_COUNT; i++) begin
            cfg_ff[i] <= pphc_pkg::CFG_RESET[i];
         end
         integ_ff <= '0;
         filt_ff  <= '0;
         last_ff  <= '0;
         aoff_ff  <= '0;
         poff_ff  <= '0;
         ready_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_valid && csr_ready
             && csr_index < pphc_pkg::CSR_INDEX_W'(pphc_pkg::REG_COUNT)) begin
            cfg_ff[csr_index[2:0]] <= csr_data;
         end
         if (in_fire && req_tuser[0]) begin
            integ_ff <= '0;
            filt_ff  <= '0;
            aoff_ff  <= req_tdata[209:178];
            poff_ff  <= req_tdata[241:210];
            last_ff  <= req_tdata[273:242];
            ready_ff <= 1'b1;
         end
         if (state_ff == pphc_pkg::ST_FUPD) begin
            filt_ff <= filt_c;
         end
         if (state_ff == pphc_pkg::ST_SLEW) begin
            integ_ff <= cand_ff;
            last_ff  <= 32'(48'(last_ff) + 48'(pphc_pkg::clamp(48'(lim_ff) - 48'(last_ff),
                                                               24'(rs))));
         end
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= $signed({1'b0, mul_g}) * mul_v;
      unique case (state_ff)
         pphc_pkg::ST_IDLE: begin
            tp_ff    <= req_tdata[31:0];
            mp_ff    <= req_tdata[63:32];
            vel_ff   <= req_tdata[95:64];
            accel_ff <= req_tdata[127:96];
            pitch_ff <= req_tdata[159:128];
            dt_ff    <= req_tdata[175:160];
            ffon_ff  <= req_tdata[176];
            fbon_ff  <= req_tdata[177];
            o_acc_ff  <= req_tuser[0];
            o_cmd_ff  <= req_tuser[0] ? req_tdata[273:242] : 32'sd0;
            o_err_ff  <= '0;
            o_filt_ff <= '0;
            o_fb_ff   <= '0;
            o_ff_ff   <= '0;
            o_req_ff  <= '0;
            o_ffa_ff  <= 1'b0;
            o_alim_ff <= 1'b0;
            o_rlim_ff <= 1'b0;
         end
         pphc_pkg::ST_PREP: begin
            err_ff    <= pphc_pkg::sat32(48'(tp_ff) - 48'(mp_ff));
            u_ff      <= pphc_pkg::sat32(48'(accel_ff) - 48'(aoff_ff));
            pu_ff     <= pphc_pkg::sat32(48'(pitch_ff) - 48'(poff_ff));
            ffterm_ff <= '0;
            fb_ff     <= '0;
            cand_ff   <= integ_ff;
            retry_ff  <= 1'b0;
            alim_ff   <= 1'b0;
         end
         pphc_pkg::ST_FLOAD: begin
            num_ff <= pphc_pkg::DIV_W'(pmag) + pphc_pkg::DIV_W'(divisor >> 1);
            neg_ff <= prod_ff[58];
            rem_ff <= '0;
            cnt_ff <= '0;
         end
         pphc_pkg::ST_FDIV: begin
            if (trial >= {1'b0, divisor}) begin
               rem_ff <= trial - {1'b0, divisor};
               num_ff <= {num_ff[pphc_pkg::DIV_W-2:0], 1'b1};
            end else begin
               rem_ff <= trial;
               num_ff <= {num_ff[pphc_pkg::DIV_W-2:0], 1'b0};
            end
            cnt_ff <= cnt_ff + 6'd1;
         end
         pphc_pkg::ST_FUPD: begin
            x_ff   <= 36'(pphc_pkg::GRAVITY_Q16);
            y_ff   <= 36'(filt_c);
            z_ff   <= '0;
            cnt_ff <= '0;
         end
         pphc_pkg::ST_CORD: begin
            if (!y_ff[35]) begin
               x_ff <= x_ff + (y_ff >>> cnt_ff[4:0]);
               y_ff <= y_ff - (x_ff >>> cnt_ff[4:0]);
               z_ff <= z_ff + $signed({16'b0, pphc_pkg::atan_entry(cnt_ff[4:0])});
            end else begin
               x_ff <= x_ff - (y_ff >>> cnt_ff[4:0]);
               y_ff <= y_ff + (x_ff >>> cnt_ff[4:0]);
               z_ff <= z_ff - $signed({16'b0, pphc_pkg::atan_entry(cnt_ff[4:0])});
            end
            cnt_ff <= cnt_ff + 6'd1;
         end
         pphc_pkg::ST_FFB: t1_ff <= rs;
         pphc_pkg::ST_FFC: ffterm_ff <= pphc_pkg::sat32(48'(t1_ff) - 48'(rs));
         pphc_pkg::ST_IADD: begin
            cand_ff <= 32'(pphc_pkg::clamp(48'(integ_ff) + 48'(rs),
                                           cfg_ff[pphc_pkg::REG_INT_CLAMP]));
         end
         pphc_pkg::ST_FB1: acc_ff <= 34'(rs);
         pphc_pkg::ST_FB2: acc_ff <= acc_ff + 34'(rs);
         pphc_pkg::ST_FB3: fb_ff <= pphc_pkg::sat32(48'(acc_ff) - 48'(rs));
         pphc_pkg::ST_REQ: begin
            req_ff  <= req_c;
            lim_ff  <= lim_c;
            alim_ff <= alim_ff | (lim_c != req_c);
            if (retry_go) begin
               cand_ff  <= integ_ff;
               retry_ff <= 1'b1;
            end
         end
         pphc_pkg::ST_SLEW: begin
            o_acc_ff  <= 1'b1;
            o_cmd_ff  <= 32'(48'(last_ff) + 48'(pphc_pkg::clamp(48'(lim_ff) - 48'(last_ff),
                                                                24'(rs))));
            o_rlim_ff <= 32'(48'(last_ff) + 48'(pphc_pkg::clamp(48'(lim_ff) - 48'(last_ff),
                                                                24'(rs)))) != lim_ff;
            o_err_ff  <= err_ff;
            o_filt_ff <= filt_ff;
            o_fb_ff   <= fb_ff;
            o_ff_ff   <= ffterm_ff;
            o_req_ff  <= req_ff;
            o_ffa_ff  <= ffon_ff;
            o_alim_ff <= alim_ff;
         end
         default: begin
         end
      endcase
   end

   assign rsp_tdata = {4'b0, o_rlim_ff, o_alim_ff, o_ffa_ff, o_req_ff, o_ff_ff, o_fb_ff,
                       o_filt_ff, o_err_ff, o_cmd_ff, o_acc_ff};

`ifndef NO_ASSERTIONS
   a_one_side: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("input and result sides open together");

   a_back_to_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready |=> req_tready)
      else $error("not ready after result taken");

   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[0] |-> rsp_tdata[195:1] == '0)
      else $error("rejected item carries data");
`endif

endmodule
`default_nettype wire

// File: test/pid_position_hold_controller_unit_test.sv
// Testbench for the position-hold angle controller: directed and random items against a predictor.
`timescale 1ns / 1ps
`default_nettype none
module pid_position_hold_controller_unit_test;

   localparam bit         CMD_STEP     = 1'b0;
   localparam bit         CMD_RESET    = 1'b1;
   localparam logic [3:0] CSR_SPARE_LO = 4'd8;
   localparam logic [3:0] CSR_SPARE_HI = 4'd15;
   localparam int         CYCLE_LIMIT  = 3000000;

   typedef struct {
      bit                 command;
      logic signed [31:0] target_pos, meas_pos, meas_vel, long_accel, pitch;
      logic [15:0]        dt;
      bit                 ff_on, fb_on;
      logic signed [31:0] accel_bias, pitch_bias, initial_angle;
   } hold_item_type;

   typedef struct {
      bit                 accepted;
      logic signed [31:0] cmd_angle, pos_err, filt_accel, fb_term, ff_term, req_angle;
      bit                 ff_active, angle_lim, rate_lim;
   } angle_result_type;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             req_tvalid = 1'b0;
   logic                             req_tready;
   logic [pphc_pkg::REQ_W-1:0]       req_tdata = '0;
   logic [0:0]                       req_tuser = '0;
   logic                             rsp_tvalid;
   logic                             rsp_tready = 1'b0;
   logic [pphc_pkg::RSP_W-1:0]       rsp_tdata;
   logic                             csr_valid = 1'b0;
   logic                             csr_ready;
   logic [pphc_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [pphc_pkg::CFG_W-1:0]       csr_data = '0;

   logic [pphc_pkg::CFG_W-1:0] ctl_reg [pphc_pkg::REG_COUNT];
   longint             integ_sum, filt_state, prev_cmd, accel_off, pitch_off;
   bit                 armed;
   angle_result_type   pending_angles [$];
   int                 send_idle_pct = 0;
   int                 rsp_stall_pct = 0;
   int                 fail_count = 0;
   longint             cycle_count = 0;

   pid_position_hold_controller_unit uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL pid_position_hold_controller_unit");
         $finish;
      end
   end

   function automatic longint sat_word(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic longint limit_sym(longint v, longint lim);
      if (v > lim) return lim;
      if (v < -lim) return -lim;
      return v;
   endfunction

   function automatic longint round_div(longint n, longint d);
      if (n >= 0) return (n + d / 2) / d;
      return -((-n + d / 2) / d);
   endfunction

   function automatic longint floor_shift(longint v, int s);
      if (v >= 0) return v >> s;
      return -(((-v) + ((64'sd1 << s) - 1)) >> s);
   endfunction

   function automatic longint gain_mul(logic [pphc_pkg::CFG_W-1:0] g, longint v);
      return sat_word(round_div(longint'(g) * v, 65536));
   endfunction

   function automatic longint tilt_angle(longint y);
      longint x, z, xs, ys;
      longint tab [17] = '{51472, 30385, 16055, 8150, 4091, 2047, 1024, 512,
                           256, 128, 64, 32, 16, 8, 4, 2, 1};
      x = pphc_pkg::GRAVITY_Q16;
      z = 0;
      for (int i = 0; i < pphc_pkg::CORDIC_STEPS; i++) begin
         xs = floor_shift(x, i);
         ys = floor_shift(y, i);
         if (y >= 0) begin
            x += ys; y -= xs; z += (i < 17) ? tab[i] : 0;
         end else begin
            x -= ys; y += xs; z -= (i < 17) ? tab[i] : 0;
         end
      end
      return z;
   endfunction

   function automatic longint pid_sum(longint err, longint integ, longint vel);
      return sat_word(gain_mul(ctl_reg[pphc_pkg::REG_GAIN_P], err)
                      + gain_mul(ctl_reg[pphc_pkg::REG_GAIN_I], integ)
                      - gain_mul(ctl_reg[pphc_pkg::REG_GAIN_D], vel));
   endfunction

   function automatic void reset_predictor();
      for (int i = 0; i < pphc_pkg::REG_COUNT; i++) ctl_reg[i] = pphc_pkg::CFG_RESET[i];
      integ_sum = 0; filt_state = 0; prev_cmd = 0; accel_off = 0; pitch_off = 0;
      armed = 0;
   endfunction

   function automatic angle_result_type advance_controller(hold_item_type it);
      angle_result_type r;
      longint           err, ff, fb, req, lim, cand, maxc, u, d, cmd;
      bit               alim;
      r = '{default: 0};
      ff = 0; fb = 0; alim = 0;
      if (it.command == CMD_RESET) begin
         integ_sum = 0; filt_state = 0;
         accel_off = it.accel_bias; pitch_off = it.pitch_bias; prev_cmd = it.initial_angle;
         armed = 1;
         r.accepted = 1;
         r.cmd_angle = it.initial_angle;
         return r;
      end
      if (!armed || it.dt == 0 || it.dt > pphc_pkg::DT_MAX
          || ctl_reg[pphc_pkg::REG_ANGLE_CLMP] == 0 || ctl_reg[pphc_pkg::REG_SLEW] == 0)
         return r;
      err = sat_word(longint'(it.target_pos) - longint'(it.meas_pos));
      if (it.ff_on) begin
         u = sat_word(longint'(it.long_accel) - accel_off);
         d = round_div((u - filt_state) * longint'(it.dt),
                       pphc_pkg::FILTER_TAU + longint'(it.dt));
         filt_state = sat_word(filt_state + d);
         ff = sat_word(gain_mul(ctl_reg[pphc_pkg::REG_ACCEL_FF], tilt_angle(filt_state))
                       - gain_mul(ctl_reg[pphc_pkg::REG_PITCH_FF],
                                  sat_word(longint'(it.pitch) - pitch_off)));
      end
      cand = integ_sum;
      if (it.fb_on) begin
         cand = limit_sym(cand + round_div(err * longint'(it.dt), 65536),
                          ctl_reg[pphc_pkg::REG_INT_CLAMP]);
         fb = pid_sum(err, cand, it.meas_vel);
      end
      req = sat_word(fb + ff);
      lim = limit_sym(req, ctl_reg[pphc_pkg::REG_ANGLE_CLMP]);
      if (lim != req) begin
         alim = 1;
         if (it.fb_on && ((req > 0 && err > 0) || (req < 0 && err < 0))) begin
            cand = integ_sum;
            fb = pid_sum(err, cand, it.meas_vel);
            req = sat_word(fb + ff);
            lim = limit_sym(req, ctl_reg[pphc_pkg::REG_ANGLE_CLMP]);
         end
      end
      integ_sum = cand;
      maxc = round_div(longint'(ctl_reg[pphc_pkg::REG_SLEW]) * longint'(it.dt), 65536);
      cmd = prev_cmd + limit_sym(lim - prev_cmd, maxc);
      prev_cmd = cmd;
      r.accepted = 1;
      r.cmd_angle = cmd; r.pos_err = err; r.filt_accel = filt_state;
      r.fb_term = fb; r.ff_term = ff; r.req_angle = req;
      r.ff_active = it.ff_on; r.angle_lim = alim; r.rate_lim = (cmd != lim);
      return r;
   endfunction

   task automatic report_mismatch(string field, longint want, longint got);
      $display("mismatch %s: expected %0d got %0d at cycle %0d", field, want, got, cycle_count);
      fail_count++;
   endtask

   task automatic compare_field(string field, longint want, longint got);
      if (want != got) report_mismatch(field, want, got);
   endtask

   always @(negedge clock) rsp_tready = ($urandom_range(99) >= rsp_stall_pct);

   always @(posedge clock) begin
      angle_result_type w;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_angles.size() == 0) begin
            report_mismatch("unexpected item", 0, 1);
         end else begin
            w = pending_angles.pop_front();
            compare_field("accepted", w.accepted, rsp_tdata[0]);
            compare_field("command_angle", w.cmd_angle, $signed(rsp_tdata[32:1]));
            compare_field("position_error", w.pos_err, $signed(rsp_tdata[64:33]));
            compare_field("filtered_accel", w.filt_accel, $signed(rsp_tdata[96:65]));
            compare_field("feedback_term", w.fb_term, $signed(rsp_tdata[128:97]));
            compare_field("feedforward_term", w.ff_term, $signed(rsp_tdata[160:129]));
            compare_field("requested_angle", w.req_angle, $signed(rsp_tdata[192:161]));
            compare_field("feedforward_active", w.ff_active, rsp_tdata[193]);
            compare_field("angle_limited", w.angle_lim, rsp_tdata[194]);
            compare_field("rate_limited", w.rate_lim, rsp_tdata[195]);
         end
      end
   end

   task automatic send_item(hold_item_type it);
      while ($urandom_range(99) < send_idle_pct) @(negedge clock);
      req_tdata = '0;
      req_tdata[273:0] = {it.initial_angle, it.pitch_bias, it.accel_bias, it.fb_on, it.ff_on,
                          it.dt, it.pitch, it.long_accel, it.meas_vel, it.meas_pos,
                          it.target_pos};
      req_tuser = it.command;
      req_tvalid = 1'b1;
      do @(posedge clock); while (!req_tready);
      pending_angles.push_back(advance_controller(it));
      @(negedge clock);
      req_tvalid = 1'b0;
   endtask

   task automatic drain_results();
      while (pending_angles.size() != 0) @(negedge clock);
      repeat (100) @(negedge clock);
   endtask

   task automatic write_register(logic [3:0] idx, logic [pphc_pkg::CFG_W-1:0] val);
      @(negedge clock);
      csr_index = idx;
      csr_data = val;
      csr_valid = 1'b1;
      do @(posedge clock); while (!csr_ready);
      if (idx < pphc_pkg::REG_COUNT) ctl_reg[idx[2:0]] = val;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   function automatic logic signed [31:0] pick_word();
      case ($urandom_range(5))
         0:       return $urandom;
         1:       return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
         2:       return $signed($urandom_range(131072)) - 65536;
         default: return $signed($urandom_range(1310720)) - 655360;
      endcase
   endfunction

   function automatic hold_item_type random_item();
      hold_item_type it;
      it.command = ($urandom_range(99) < 6) ? CMD_RESET : CMD_STEP;
      it.target_pos = pick_word(); it.meas_pos = pick_word(); it.meas_vel = pick_word();
      it.long_accel = pick_word(); it.pitch = pick_word();
      case ($urandom_range(19))
         0:       it.dt = 16'($urandom);
         1:       it.dt = $urandom_range(1) ? 16'd0 : 16'(pphc_pkg::DT_MAX + 1);
         2:       it.dt = $urandom_range(1) ? 16'd1 : 16'(pphc_pkg::DT_MAX);
         default: it.dt = 16'($urandom_range(pphc_pkg::DT_MAX, 1));
      endcase
      it.ff_on = 1'($urandom); it.fb_on = 1'($urandom);
      it.accel_bias = pick_word(); it.pitch_bias = pick_word();
      it.initial_angle = ($urandom_range(3) == 0) ? pick_word()
                         : $signed($urandom_range(8000)) - 4000;
      return it;
   endfunction

   function automatic hold_item_type quiet_item(bit command, logic [15:0] dt, bit ffon,
                                                bit fbon);
      hold_item_type it;
      it = '{default: 0};
      it.command = command; it.dt = dt; it.ff_on = ffon; it.fb_on = fbon;
      return it;
   endfunction

   task automatic test_directed();
      hold_item_type it;
      send_item(quiet_item(CMD_STEP, 16'd100, 1, 1));
      it = quiet_item(CMD_RESET, 16'd0, 0, 0);
      it.accel_bias = 32'sh80000000; it.pitch_bias = 32'sh7fffffff;
      it.initial_angle = 32'sh7fffffff; it.target_pos = 32'sh7fffffff;
      send_item(it);
      send_item(quiet_item(CMD_STEP, 16'd0, 1, 1));
      send_item(quiet_item(CMD_STEP, 16'(pphc_pkg::DT_MAX + 1), 1, 1));
      send_item(quiet_item(CMD_STEP, 16'hffff, 1, 1));
      it = quiet_item(CMD_STEP, 16'(pphc_pkg::DT_MAX), 1, 1);
      it.target_pos = 32'sh7fffffff; it.meas_pos = 32'sh80000000;
      it.meas_vel = 32'sh80000000; it.long_accel = 32'sh7fffffff; it.pitch = 32'sh80000000;
      send_item(it);
      it = quiet_item(CMD_RESET, 16'd0, 0, 0);
      send_item(it);
      for (int k = 0; k < 4; k++) begin
         it = quiet_item(CMD_STEP, 16'd1, k[0], k[1]);
         it.target_pos = 32'sh80000000; it.meas_pos = 32'sh7fffffff;
         it.meas_vel = 32'sh7fffffff; it.long_accel = 32'sh80000000; it.pitch = 32'sh7fffffff;
         send_item(it);
      end
      for (int k = 0; k < 6; k++) begin
         it = quiet_item(CMD_STEP, 16'd655, 1, 1);
         it.target_pos = (k < 3) ? 32'sd655360 : -32'sd655360;
         it.long_accel = -32'sd200000 + k * 80000;
         send_item(it);
      end
      drain_results();
   endtask

   task automatic test_register_extremes();
      hold_item_type it;
      write_register({1'b0, pphc_pkg::REG_ANGLE_CLMP}, '0);
      it = quiet_item(CMD_STEP, 16'd100, 1, 1);
      send_item(it);
      drain_results();
      write_register({1'b0, pphc_pkg::REG_ANGLE_CLMP}, 24'd3431);
      write_register({1'b0, pphc_pkg::REG_SLEW}, '0);
      send_item(it);
      drain_results();
      for (int r = 0; r < pphc_pkg::REG_COUNT; r++) write_register(4'(r), 24'hffffff);
      write_register(CSR_SPARE_LO, 24'd1);
      write_register(CSR_SPARE_HI, 24'h555555);
      for (int k = 0; k < 6; k++) send_item(random_item());
      drain_results();
      write_register({1'b0, pphc_pkg::REG_ANGLE_CLMP}, 24'd1);
      write_register({1'b0, pphc_pkg::REG_SLEW}, 24'd1);
      write_register({1'b0, pphc_pkg::REG_INT_CLAMP}, '0);
      for (int k = 0; k < 5; k++) send_item(random_item());
      drain_results();
   endtask

   task automatic randomise_registers();
      write_register({1'b0, pphc_pkg::REG_GAIN_P}, 24'($urandom_range(200000)));
      write_register({1'b0, pphc_pkg::REG_GAIN_I}, 24'($urandom_range(100000)));
      write_register({1'b0, pphc_pkg::REG_GAIN_D}, 24'($urandom_range(100000)));
      write_register({1'b0, pphc_pkg::REG_INT_CLAMP},
                     24'($urandom_range(3) ? $urandom_range(20000) : $urandom));
      write_register({1'b0, pphc_pkg::REG_ACCEL_FF},
                     24'($urandom_range(3) ? $urandom_range(131072) : $urandom));
      write_register({1'b0, pphc_pkg::REG_PITCH_FF}, 24'($urandom_range(131072)));
      write_register({1'b0, pphc_pkg::REG_ANGLE_CLMP},
                     24'($urandom_range(3) ? $urandom_range(20000, 1)
                                           : $urandom_range(24'hffffff, 1)));
      write_register({1'b0, pphc_pkg::REG_SLEW},
                     24'($urandom_range(3) ? $urandom_range(100000, 1)
                                           : $urandom_range(24'hffffff, 1)));
   endtask

   task automatic test_random_phase(int idle, int stall, int count, bit pause);
      drain_results();
      send_idle_pct = idle;
      rsp_stall_pct = stall;
      randomise_registers();
      for (int k = 0; k < count; k++) begin
         if (k > 0 && k % 55 == 0) begin
            drain_results();
            randomise_registers();
         end else if (pause && k == count / 2) begin
            drain_results();
         end
         send_item(random_item());
      end
      drain_results();
   endtask

   initial begin
      reset_predictor();
      reset = 1'b1;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_directed();
      test_register_extremes();
      test_random_phase(0, 0, 165, 1'b1);
      test_random_phase(87, 0, 165, 1'b0);
      test_random_phase(0, 87, 165, 1'b1);
      test_random_phase(28, 28, 165, 1'b0);
      if (fail_count == 0 && pending_angles.size() == 0) begin
         $display("PASS pid_position_hold_controller_unit");
      end else begin
         $display("FAIL pid_position_hold_controller_unit");
      end
      $finish;
   end
endmodule
`default_nettype wire
